/* hw/rtl/kiv_pkg.sv */
// kiv_pkg: shared sizes, codes and types of the keyed iv table schedule unit
// no dependencies; used by kiv_table and keyed_iv_table_schedule_unit

package kiv_pkg;

  // table geometry
  localparam int TABLE_ROWS  = 800;
  localparam int STREAMS     = 4;
  localparam int NAME_BYTES  = 32;
  localparam int ROW_WORDS   = 5;
  localparam int IV_WORDS    = 2;
  localparam int TABLE_WORDS = TABLE_ROWS * ROW_WORDS;
  localparam int CTR_WRAP    = (TABLE_ROWS / STREAMS) > 0 ? (TABLE_ROWS / STREAMS) : 1;

  // widths
  localparam int ADDR_W     = $clog2(TABLE_WORDS);
  localparam int ROW_W      = 10;
  localparam int CTR_W      = $clog2(CTR_WRAP) > 0 ? $clog2(CTR_WRAP) : 1;
  localparam int STREAM_W   = 2;
  localparam int WIDX_W     = $clog2(ROW_WORDS + 1);
  localparam int NAME_IDX_W = $clog2(NAME_BYTES) > 0 ? $clog2(NAME_BYTES) : 1;
  localparam int LEN_W      = 6;
  localparam int NAME_W     = 256;
  localparam int HASH_W     = 160;
  localparam int IV_W       = 64;
  localparam int CFG_IDX_W  = 3;

  // input word kinds
  typedef enum logic [1:0] {
    MODE_RESTART = 2'd0,
    MODE_FETCH   = 2'd1,
    MODE_ABSORB  = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NAME0    = 3'd0,
    CFG_NAME1    = 3'd1,
    CFG_NAME2    = 3'd2,
    CFG_NAME3    = 3'd3,
    CFG_NAME_LEN = 3'd4
  } cfg_idx_t;

  // table sequencer operations
  typedef enum logic [1:0] {
    OP_FILL   = 2'd0,
    OP_FETCH  = 2'd1,
    OP_ABSORB = 2'd2
  } tbl_op_t;

  // top level control states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_START = 2'd1,
    S_BUSY  = 2'd2,
    S_DONE  = 2'd3
  } top_state_t;

  // table sequencer states
  typedef enum logic [1:0] {
    T_IDLE   = 2'd0,
    T_FILL   = 2'd1,
    T_FETCH  = 2'd2,
    T_ABSORB = 2'd3
  } tbl_state_t;

  // command into the table sequencer
  typedef struct packed {
    logic             start;
    tbl_op_t          op;
    logic [ROW_W-1:0] row;
    logic [LEN_W-1:0] name_len;
  } tbl_cmd_t;

  // status back from the table sequencer
  typedef struct packed {
    logic            done;
    logic [IV_W-1:0] iv;
  } tbl_stat_t;

  // name length as used by the fill: zero counts as one, saturate at NAME_BYTES
  function automatic logic [LEN_W-1:0] used_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (n == '0) n = LEN_W'(1);
    if (n > LEN_W'(NAME_BYTES)) n = LEN_W'(NAME_BYTES);
    return n;
  endfunction

endpackage

/* hw/rtl/kiv_table.sv */
// kiv_table: iv table memory (32-bit words) and its word sequencer
// runs fill, fetch and absorb passes; depends on kiv_pkg

module kiv_table (
  input  logic                         clk,
  input  logic                         rst,
  input  kiv_pkg::tbl_cmd_t            cmd,
  input  logic [kiv_pkg::NAME_W-1:0]   name_chars,
  input  logic [kiv_pkg::HASH_W-1:0]   hash,
  output kiv_pkg::tbl_stat_t           stat
);

  // table storage, one read and one write port
  logic [31:0] mem [kiv_pkg::TABLE_WORDS];
  logic [31:0] rdata;

  kiv_pkg::tbl_state_t state, state_next;

  logic [kiv_pkg::ADDR_W-1:0]     base;
  logic [kiv_pkg::WIDX_W-1:0]     idx;
  logic                           rv;
  logic [kiv_pkg::WIDX_W-1:0]     rk;
  logic [31:0]                    iv_lo;
  logic [kiv_pkg::ADDR_W-1:0]     fill_addr;
  logic [kiv_pkg::NAME_IDX_W-1:0] name_idx;
  logic [kiv_pkg::LEN_W-1:0]      name_len;

  logic [31:0]                 hash_w [kiv_pkg::ROW_WORDS];
  logic [kiv_pkg::WIDX_W-1:0]  nwords;
  logic [kiv_pkg::WIDX_W-1:0]  last;
  logic                        re;
  logic [kiv_pkg::ADDR_W-1:0]  raddr;
  logic                        we;
  logic [kiv_pkg::ADDR_W-1:0]  waddr;
  logic [31:0]                 wdata;
  logic [7:0]                  name_byte;
  logic                        done;

  // split the hash into table words
  for (genvar k = 0; k < kiv_pkg::ROW_WORDS; k++) begin : g_hash
    assign hash_w[k] = hash[32*k +: 32];
  end

  assign name_byte = name_chars[{name_idx, 3'b000} +: 8];

  // access sequence and next state
  always_comb begin
    nwords     = (state == kiv_pkg::T_FETCH) ? kiv_pkg::WIDX_W'(kiv_pkg::IV_WORDS)
                                             : kiv_pkg::WIDX_W'(kiv_pkg::ROW_WORDS);
    last       = nwords - kiv_pkg::WIDX_W'(1);
    re         = ((state == kiv_pkg::T_FETCH) || (state == kiv_pkg::T_ABSORB)) &&
                 (idx < nwords);
    raddr      = base + kiv_pkg::ADDR_W'(idx);
    we         = 1'b0;
    waddr      = base + kiv_pkg::ADDR_W'(rk);
    wdata      = rdata ^ hash_w[rk];
    done       = 1'b0;
    state_next = state;
    case (state)
      kiv_pkg::T_IDLE: begin
        if (cmd.start) begin
          case (cmd.op)
            kiv_pkg::OP_FILL:   state_next = kiv_pkg::T_FILL;
            kiv_pkg::OP_FETCH:  state_next = kiv_pkg::T_FETCH;
            kiv_pkg::OP_ABSORB: state_next = kiv_pkg::T_ABSORB;
            default:            state_next = kiv_pkg::T_IDLE;
          endcase
        end
      end
      kiv_pkg::T_FILL: begin
        we    = 1'b1;
        waddr = fill_addr;
        wdata = {4{name_byte}};
        if (fill_addr == kiv_pkg::ADDR_W'(kiv_pkg::TABLE_WORDS - 1)) begin
          done       = 1'b1;
          state_next = kiv_pkg::T_IDLE;
        end
      end
      kiv_pkg::T_FETCH: begin
        if (rv && (rk == last)) begin
          done       = 1'b1;
          state_next = kiv_pkg::T_IDLE;
        end
      end
      kiv_pkg::T_ABSORB: begin
        we = rv;
        if (rv && (rk == last)) begin
          done       = 1'b1;
          state_next = kiv_pkg::T_IDLE;
        end
      end
      default: state_next = kiv_pkg::T_IDLE;
    endcase
  end

  assign stat.done = done;
  assign stat.iv   = {rdata, iv_lo};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kiv_pkg::T_IDLE;
      rv    <= 1'b0;
    end else begin
      state <= state_next;
      rv    <= re;
    end
  end

  // sequencer counters and captured data
  always_ff @(posedge clk) begin
    if (state == kiv_pkg::T_IDLE) begin
      base      <= kiv_pkg::ADDR_W'(cmd.row) * kiv_pkg::ADDR_W'(kiv_pkg::ROW_WORDS);
      idx       <= '0;
      fill_addr <= '0;
      name_idx  <= '0;
      name_len  <= kiv_pkg::used_len(cmd.name_len);
    end else begin
      if (re) idx <= idx + kiv_pkg::WIDX_W'(1);
      rk <= idx;
      if (rv && (rk == '0)) iv_lo <= rdata;
      if (state == kiv_pkg::T_FILL) begin
        fill_addr <= fill_addr + kiv_pkg::ADDR_W'(1);
        if (kiv_pkg::LEN_W'(name_idx) == name_len - kiv_pkg::LEN_W'(1)) begin
          name_idx <= '0;
        end else begin
          name_idx <= name_idx + kiv_pkg::NAME_IDX_W'(1);
        end
      end
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // checks
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> state == kiv_pkg::T_IDLE)
    else $error("table command while a pass runs");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    we |-> waddr < kiv_pkg::ADDR_W'(kiv_pkg::TABLE_WORDS))
    else $error("table write outside the table");

  a_read_order: assert property (@(posedge clk) disable iff (rst)
    rv |-> rk <= last)
    else $error("read data beyond the words of the pass");

endmodule

/* hw/rtl/keyed_iv_table_schedule_unit.sv */
// keyed_iv_table_schedule_unit: top level, handshakes, config, stream counters
// depends on kiv_pkg and kiv_table
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | tuser mode, tdata stream+hash
//  m_       | out       | m_tvalid/m_tready  | tdata iv_value+row_used
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  a fetch reads two words, an absorb reads and rewrites five, a restart writes all 4000: the table memory moves one
//  32-bit word per cycle through its single read and single write port.
//  reset sets every stream counter to 1, name bytes to 0 and name length to 1;
//  the table holds nothing defined until a restart fills it.
//  a finished word waits in the output register while the next input is taken;
//  if it is still waiting when the next result is ready, the unit holds there.

module keyed_iv_table_schedule_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [167:0]                    s_tdata,   // stream, hash_low, hash_mid, hash_high
  input  logic [1:0]                      s_tuser,   // mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [79:0]                     m_tdata,   // iv_value, row_used
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kiv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_data
);

  kiv_pkg::top_state_t state, state_next;

  logic [kiv_pkg::NAME_W-1:0]   name_chars;
  logic [kiv_pkg::LEN_W-1:0]    name_len;
  logic [kiv_pkg::CTR_W-1:0]    cnt [kiv_pkg::STREAMS];

  kiv_pkg::mode_t               mode_r;
  logic [kiv_pkg::HASH_W-1:0]   hash_r;
  logic [kiv_pkg::ROW_W-1:0]    row_r;
  logic [kiv_pkg::IV_W-1:0]     iv_r;

  logic [kiv_pkg::STREAM_W-1:0] in_stream;
  kiv_pkg::mode_t               in_mode;
  logic [kiv_pkg::CTR_W-1:0]    c_cur;
  logic [kiv_pkg::CTR_W-1:0]    c_prev;
  logic [kiv_pkg::CTR_W-1:0]    c_inc;
  logic [kiv_pkg::CTR_W-1:0]    c_sel;
  logic [kiv_pkg::ROW_W-1:0]    row_in;
  logic [kiv_pkg::ROW_W-1:0]    row_out;
  logic                         accept;
  logic                         load_out;
  kiv_pkg::tbl_cmd_t            cmd;
  kiv_pkg::tbl_stat_t           stat;

  assign cfg_ready = 1'b1;
  assign in_stream = s_tdata[1:0];
  assign in_mode   = kiv_pkg::mode_t'(s_tuser);
  assign accept    = s_tvalid && s_tready;

  // row select from the stream counter
  always_comb begin
    c_cur  = cnt[in_stream];
    c_prev = (c_cur == '0) ? kiv_pkg::CTR_W'(kiv_pkg::CTR_WRAP - 1)
                           : c_cur - kiv_pkg::CTR_W'(1);
    c_inc  = (c_cur == kiv_pkg::CTR_W'(kiv_pkg::CTR_WRAP - 1)) ? '0
                                                              : c_cur + kiv_pkg::CTR_W'(1);
    c_sel  = (in_mode == kiv_pkg::MODE_FETCH) ? c_prev : c_cur;
    row_in = kiv_pkg::ROW_W'(c_sel) * kiv_pkg::ROW_W'(kiv_pkg::STREAMS) +
             kiv_pkg::ROW_W'(in_stream);
  end

  assign row_out = ((mode_r == kiv_pkg::MODE_FETCH) || (mode_r == kiv_pkg::MODE_ABSORB))
                   ? row_r : '0;

  // next state and table command
  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    load_out     = 1'b0;
    cmd.start    = 1'b0;
    cmd.row      = row_r;
    cmd.name_len = name_len;
    case (mode_r)
      kiv_pkg::MODE_RESTART: cmd.op = kiv_pkg::OP_FILL;
      kiv_pkg::MODE_FETCH:   cmd.op = kiv_pkg::OP_FETCH;
      default:               cmd.op = kiv_pkg::OP_ABSORB;
    endcase
    case (state)
      kiv_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (in_mode == kiv_pkg::MODE_NONE) ? kiv_pkg::S_DONE : kiv_pkg::S_START;
        end
      end
      kiv_pkg::S_START: begin
        cmd.start  = 1'b1;
        state_next = kiv_pkg::S_BUSY;
      end
      kiv_pkg::S_BUSY: begin
        if (stat.done) state_next = kiv_pkg::S_DONE;
      end
      kiv_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = kiv_pkg::S_IDLE;
        end
      end
      default: state_next = kiv_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kiv_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      name_chars <= '0;
      name_len   <= kiv_pkg::LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (kiv_pkg::cfg_idx_t'(cfg_index))
        kiv_pkg::CFG_NAME0:    name_chars[63:0]    <= cfg_data;
        kiv_pkg::CFG_NAME1:    name_chars[127:64]  <= cfg_data;
        kiv_pkg::CFG_NAME2:    name_chars[191:128] <= cfg_data;
        kiv_pkg::CFG_NAME3:    name_chars[255:192] <= cfg_data;
        kiv_pkg::CFG_NAME_LEN: name_len            <= cfg_data[kiv_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // stream counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kiv_pkg::STREAMS; i++) begin
        cnt[i] <= kiv_pkg::CTR_W'(1 % kiv_pkg::CTR_WRAP);
      end
    end else if (accept) begin
      if (in_mode == kiv_pkg::MODE_RESTART) begin
        for (int i = 0; i < kiv_pkg::STREAMS; i++) begin
          cnt[i] <= kiv_pkg::CTR_W'(1 % kiv_pkg::CTR_WRAP);
        end
      end else if (in_mode == kiv_pkg::MODE_ABSORB) begin
        cnt[in_stream] <= c_inc;
      end
    end
  end

  // captured input word and result
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      hash_r <= s_tdata[161:2];
      row_r  <= row_in;
      iv_r   <= '0;
    end else if ((state == kiv_pkg::S_BUSY) && stat.done &&
                 (mode_r == kiv_pkg::MODE_FETCH)) begin
      iv_r <= stat.iv;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) m_tdata <= {6'b0, row_out, iv_r};
  end

  kiv_table u_table (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .name_chars (name_chars),
    .hash       (hash_r),
    .stat       (stat)
  );

  // checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second input word taken while one is in work");

  a_done_when_busy: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == kiv_pkg::S_BUSY)
    else $error("table pass ended outside the busy state");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    load_out |-> row_out < kiv_pkg::ROW_W'(kiv_pkg::TABLE_ROWS))
    else $error("result row beyond the table");

  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    cnt[in_stream] < kiv_pkg::CTR_W'(kiv_pkg::CTR_WRAP - 1) ||
    cnt[in_stream] == kiv_pkg::CTR_W'(kiv_pkg::CTR_WRAP - 1))
    else $error("stream counter out of range");

endmodule
